>>> rtl/lpps_pkg.sv
// Shared types and constants for the lattice particle pair step block.
package lpps_pkg;

  // Table and grid geometry
  localparam int PARTICLE_COUNT = 1024;
  localparam int IDX_W          = $clog2(PARTICLE_COUNT);
  localparam int GRID_WIDTH     = 80;
  localparam int GRID_HEIGHT    = 25;
  localparam int X_W            = 7;
  localparam int Y_W            = 5;
  localparam int GRID_CELLS     = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_W         = $clog2(GRID_CELLS);

  // Command codes of an input transaction
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_INTERACT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_BOUNDARY_MODE  = 1'b0;
  localparam logic CFG_POTENTIAL_SIGN = 1'b1;

  // Grid cell marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_POS   = 2'd1;
  localparam logic [1:0] MARK_NEG   = 2'd3;

  // One particle table entry
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           neg;
  } particle_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LOAD,
    OP_RD_B,
    OP_CAP_B,
    OP_PLAN,
    OP_RD_GRID_A,
    OP_CLR_A,
    OP_MARK_A,
    OP_RD_GRID_B,
    OP_CLR_B,
    OP_MARK_B
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic same_index;
    logic cell_empty;
  } dp_status_t;

endpackage

>>> rtl/lpps_ctrl.sv
// Controller state machine: sequences grid clear, load and pair interaction.
module lpps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  lpps_pkg::dp_status_t  status,
  output lpps_pkg::dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_RD_B,
    S_CAP_B,
    S_PLAN,
    S_CHK_A,
    S_TST_A,
    S_MARK_A,
    S_CHK_B,
    S_TST_B,
    S_MARK_B,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op        = lpps_pkg::OP_NONE;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = lpps_pkg::OP_CLEAR;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = lpps_pkg::OP_CAPTURE;
          state_nxt = (in_command == lpps_pkg::CMD_LOAD) ? S_LOAD : S_RD_B;
        end
      end
      S_LOAD: begin
        cmd.op    = lpps_pkg::OP_LOAD;
        state_nxt = S_RESULT;
      end
      S_RD_B: begin
        cmd.op    = lpps_pkg::OP_RD_B;
        state_nxt = S_CAP_B;
      end
      S_CAP_B: begin
        cmd.op    = lpps_pkg::OP_CAP_B;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        cmd.op    = lpps_pkg::OP_PLAN;
        state_nxt = status.same_index ? S_RESULT : S_CHK_A;
      end
      S_CHK_A: begin
        cmd.op    = lpps_pkg::OP_RD_GRID_A;
        state_nxt = S_TST_A;
      end
      S_TST_A: begin
        // target empty: clear old cell now, mark the new one next
        if (status.cell_empty) begin
          cmd.op    = lpps_pkg::OP_CLR_A;
          state_nxt = S_MARK_A;
        end else begin
          state_nxt = S_CHK_B;
        end
      end
      S_MARK_A: begin
        cmd.op    = lpps_pkg::OP_MARK_A;
        state_nxt = S_CHK_B;
      end
      S_CHK_B: begin
        cmd.op    = lpps_pkg::OP_RD_GRID_B;
        state_nxt = S_TST_B;
      end
      S_TST_B: begin
        if (status.cell_empty) begin
          cmd.op    = lpps_pkg::OP_CLR_B;
          state_nxt = S_MARK_B;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_MARK_B: begin
        cmd.op    = lpps_pkg::OP_MARK_B;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/lpps_dp.sv
// Datapath: particle table, occupancy grid, move arithmetic and result register.
module lpps_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpps_pkg::dp_cmd_t                 cmd,
  output lpps_pkg::dp_status_t              status,
  input  logic                              boundary_mode,
  input  logic                              potential_sign,
  input  logic                              in_command,
  input  logic [lpps_pkg::IDX_W-1:0]        in_first_index,
  input  logic [lpps_pkg::IDX_W-1:0]        in_second_index,
  input  logic [lpps_pkg::X_W-1:0]          in_load_x,
  input  logic [lpps_pkg::Y_W-1:0]          in_load_y,
  input  logic                              in_load_charge,
  output logic [lpps_pkg::X_W-1:0]          out_first_x,
  output logic [lpps_pkg::Y_W-1:0]          out_first_y,
  output logic [lpps_pkg::X_W-1:0]          out_second_x,
  output logic [lpps_pkg::Y_W-1:0]          out_second_y,
  output logic                              out_first_moved,
  output logic                              out_second_moved
);

  // signed width for differences, shifts and unreduced coordinates
  localparam int D_W = lpps_pkg::X_W + 2;

  // truncating divide by four of a signed value
  function automatic logic signed [D_W-1:0] quarter(input logic signed [D_W-1:0] n);
    logic signed [D_W-1:0] mag;
    mag = n[D_W-1] ? -n : n;
    mag = mag >>> 2;
    return n[D_W-1] ? -mag : mag;
  endfunction

  // new coordinate: wrap by one period or clamp to the grid edge
  function automatic logic signed [D_W-1:0] place(input logic signed [D_W-1:0] pos,
                                                  input logic signed [D_W-1:0] delta,
                                                  input logic signed [D_W-1:0] size,
                                                  input logic clamp);
    logic signed [D_W-1:0] v;
    v = pos + delta;
    if (clamp) begin
      if (v < 0) v = '0;
      else if (v > size - 1) v = size - 1;
    end else begin
      if (v < 0) v = v + size;
      else if (v >= size) v = v - size;
    end
    return v;
  endfunction

  function automatic logic [lpps_pkg::CELL_W-1:0] cell_of(input logic [lpps_pkg::X_W-1:0] x,
                                                          input logic [lpps_pkg::Y_W-1:0] y);
    return lpps_pkg::CELL_W'(y) * lpps_pkg::CELL_W'(lpps_pkg::GRID_WIDTH)
         + lpps_pkg::CELL_W'(x);
  endfunction

  function automatic logic [1:0] mark_of(input logic neg);
    return neg ? lpps_pkg::MARK_NEG : lpps_pkg::MARK_POS;
  endfunction

  // memories
  lpps_pkg::particle_t tbl_mem [lpps_pkg::PARTICLE_COUNT];
  logic [1:0]          grid_mem [lpps_pkg::GRID_CELLS];

  // captured transaction
  logic                         cmd_r;
  logic [lpps_pkg::IDX_W-1:0]   ia_r, ib_r;
  logic [lpps_pkg::X_W-1:0]     lx_r;
  logic [lpps_pkg::Y_W-1:0]     ly_r;
  logic                         lc_r;

  // working registers
  lpps_pkg::particle_t          pa_r, pb_r, tbl_rdata_r;
  logic [lpps_pkg::X_W-1:0]     ca_x_r, cb_x_r;
  logic [lpps_pkg::Y_W-1:0]     ca_y_r, cb_y_r;
  logic                         moved_a_r, moved_b_r;
  logic [1:0]                   grid_rdata_r;
  logic [lpps_pkg::CELL_W-1:0]  clr_cnt_r;

  // result register
  logic [lpps_pkg::X_W-1:0]     res_ax_r, res_bx_r;
  logic [lpps_pkg::Y_W-1:0]     res_ay_r, res_by_r;
  logic                         res_am_r, res_bm_r;

  // memory port signals
  logic [lpps_pkg::IDX_W-1:0]   tbl_raddr, tbl_waddr;
  logic                         tbl_we;
  lpps_pkg::particle_t          tbl_wdata;
  logic [lpps_pkg::CELL_W-1:0]  grid_raddr, grid_waddr;
  logic                         grid_we;
  logic [1:0]                   grid_wdata;

  // move arithmetic
  logic                         negate;
  logic signed [D_W-1:0]        dx, dy, sx, sy;
  logic signed [D_W-1:0]        na_x, na_y, nb_x, nb_y;
  logic [lpps_pkg::X_W-1:0]     lx_clamped;
  logic [lpps_pkg::Y_W-1:0]     ly_clamped;

  assign status.clear_last = (clr_cnt_r == lpps_pkg::CELL_W'(lpps_pkg::GRID_CELLS - 1));
  assign status.same_index = (ia_r == ib_r);
  assign status.cell_empty = (grid_rdata_r == lpps_pkg::MARK_EMPTY);

  // load coordinates clamped to the grid
  assign lx_clamped = (in_load_x > lpps_pkg::X_W'(lpps_pkg::GRID_WIDTH - 1))
                    ? lpps_pkg::X_W'(lpps_pkg::GRID_WIDTH - 1) : in_load_x;
  assign ly_clamped = (in_load_y > lpps_pkg::Y_W'(lpps_pkg::GRID_HEIGHT - 1))
                    ? lpps_pkg::Y_W'(lpps_pkg::GRID_HEIGHT - 1) : in_load_y;

  // shift per axis and candidate cells, first plus and second minus
  always_comb begin
    negate = potential_sign ^ pa_r.neg ^ pb_r.neg;
    dx     = $signed(D_W'(pb_r.x)) - $signed(D_W'(pa_r.x));
    dy     = $signed(D_W'(pb_r.y)) - $signed(D_W'(pa_r.y));
    sx     = quarter(negate ? -dx : dx);
    sy     = quarter(negate ? -dy : dy);
    na_x   = place($signed(D_W'(pa_r.x)), sx, D_W'(lpps_pkg::GRID_WIDTH), boundary_mode);
    na_y   = place($signed(D_W'(pa_r.y)), sy, D_W'(lpps_pkg::GRID_HEIGHT), boundary_mode);
    nb_x   = place($signed(D_W'(pb_r.x)), -sx, D_W'(lpps_pkg::GRID_WIDTH), boundary_mode);
    nb_y   = place($signed(D_W'(pb_r.y)), -sy, D_W'(lpps_pkg::GRID_HEIGHT), boundary_mode);
  end

  // table port selection
  always_comb begin
    tbl_raddr = ia_r;
    tbl_we    = 1'b0;
    tbl_waddr = ia_r;
    tbl_wdata = pa_r;
    case (cmd.op)
      lpps_pkg::OP_CAPTURE: tbl_raddr = in_first_index;
      lpps_pkg::OP_RD_B:    tbl_raddr = ib_r;
      lpps_pkg::OP_LOAD: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{x: lx_r, y: ly_r, neg: lc_r};
      end
      lpps_pkg::OP_MARK_A: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{x: ca_x_r, y: ca_y_r, neg: pa_r.neg};
      end
      lpps_pkg::OP_MARK_B: begin
        tbl_we    = 1'b1;
        tbl_waddr = ib_r;
        tbl_wdata = '{x: cb_x_r, y: cb_y_r, neg: pb_r.neg};
      end
      default: ;
    endcase
  end

  // grid port selection
  always_comb begin
    grid_raddr = cell_of(cb_x_r, cb_y_r);
    grid_we    = 1'b1;
    grid_waddr = cell_of(pa_r.x, pa_r.y);
    grid_wdata = lpps_pkg::MARK_EMPTY;
    case (cmd.op)
      lpps_pkg::OP_RD_GRID_A: begin
        grid_raddr = cell_of(ca_x_r, ca_y_r);
        grid_we    = 1'b0;
      end
      lpps_pkg::OP_CLEAR:  grid_waddr = clr_cnt_r;
      lpps_pkg::OP_LOAD: begin
        grid_waddr = cell_of(lx_r, ly_r);
        grid_wdata = mark_of(lc_r);
      end
      lpps_pkg::OP_CLR_A:  grid_waddr = cell_of(pa_r.x, pa_r.y);
      lpps_pkg::OP_MARK_A: begin
        grid_waddr = cell_of(ca_x_r, ca_y_r);
        grid_wdata = mark_of(pa_r.neg);
      end
      lpps_pkg::OP_CLR_B:  grid_waddr = cell_of(pb_r.x, pb_r.y);
      lpps_pkg::OP_MARK_B: begin
        grid_waddr = cell_of(cb_x_r, cb_y_r);
        grid_wdata = mark_of(pb_r.neg);
      end
      default: grid_we = 1'b0;
    endcase
  end

  // particle table memory
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata_r <= tbl_mem[tbl_raddr];
  end

  // occupancy grid memory
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    grid_rdata_r <= grid_mem[grid_raddr];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.op == lpps_pkg::OP_CLEAR && !status.clear_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lpps_pkg::OP_CAPTURE: begin
        cmd_r <= in_command;
        ia_r  <= in_first_index;
        ib_r  <= in_second_index;
        lx_r  <= lx_clamped;
        ly_r  <= ly_clamped;
        lc_r  <= in_load_charge;
      end
      lpps_pkg::OP_RD_B:  pa_r <= tbl_rdata_r;
      lpps_pkg::OP_CAP_B: pb_r <= tbl_rdata_r;
      lpps_pkg::OP_PLAN: begin
        ca_x_r    <= na_x[lpps_pkg::X_W-1:0];
        ca_y_r    <= na_y[lpps_pkg::Y_W-1:0];
        cb_x_r    <= nb_x[lpps_pkg::X_W-1:0];
        cb_y_r    <= nb_y[lpps_pkg::Y_W-1:0];
        moved_a_r <= 1'b0;
        moved_b_r <= 1'b0;
      end
      lpps_pkg::OP_MARK_A: begin
        pa_r      <= '{x: ca_x_r, y: ca_y_r, neg: pa_r.neg};
        moved_a_r <= (ca_x_r != pa_r.x) || (ca_y_r != pa_r.y);
      end
      lpps_pkg::OP_MARK_B: begin
        pb_r      <= '{x: cb_x_r, y: cb_y_r, neg: pb_r.neg};
        moved_b_r <= (cb_x_r != pb_r.x) || (cb_y_r != pb_r.y);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd_r == lpps_pkg::CMD_LOAD) begin
        res_ax_r <= lx_r;
        res_ay_r <= ly_r;
        res_bx_r <= '0;
        res_by_r <= '0;
        res_am_r <= 1'b0;
        res_bm_r <= 1'b0;
      end else begin
        res_ax_r <= pa_r.x;
        res_ay_r <= pa_r.y;
        res_bx_r <= pb_r.x;
        res_by_r <= pb_r.y;
        res_am_r <= moved_a_r;
        res_bm_r <= moved_b_r;
      end
    end
  end

  assign out_first_x      = res_ax_r;
  assign out_first_y      = res_ay_r;
  assign out_second_x     = res_bx_r;
  assign out_second_y     = res_by_r;
  assign out_first_moved  = res_am_r;
  assign out_second_moved = res_bm_r;

endmodule

>>> rtl/lattice_particle_pair_step.sv
// Top level of the lattice particle pair step block: config registers and wiring.
//
// After reset the block runs a clearing pass over the 2000-cell occupancy grid,
// one cell per cycle, and holds in_ready low until the pass ends; configuration
// writes are taken throughout. Items are handled one at a time. A load writes the
// table and the grid and then enters the output register; an interaction reads
// both table entries, plans both moves, then checks and moves each particle in
// turn, skipping a particle whose target cell is taken, and a pair with equal
// indices skips the moves. The controller gives each table read, grid read and
// grid write its own state, and the second particle's grid check must see the
// first particle's move. The output register lets the next item enter while a
// result still waits to be taken; a new result that finds it still full holds
// the block until it drains.
module lattice_particle_pair_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [lpps_pkg::IDX_W-1:0]  in_first_index,
  input  logic [lpps_pkg::IDX_W-1:0]  in_second_index,
  input  logic [lpps_pkg::X_W-1:0]    in_load_x,
  input  logic [lpps_pkg::Y_W-1:0]    in_load_y,
  input  logic                        in_load_charge,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpps_pkg::X_W-1:0]    out_first_x,
  output logic [lpps_pkg::Y_W-1:0]    out_first_y,
  output logic [lpps_pkg::X_W-1:0]    out_second_x,
  output logic [lpps_pkg::Y_W-1:0]    out_second_y,
  output logic                        out_first_moved,
  output logic                        out_second_moved
);

  logic                  boundary_mode_r;
  logic                  potential_sign_r;
  lpps_pkg::dp_cmd_t     dp_cmd;
  lpps_pkg::dp_status_t  dp_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boundary_mode_r  <= 1'b1;
      potential_sign_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpps_pkg::CFG_BOUNDARY_MODE:  boundary_mode_r  <= cfg_data;
        lpps_pkg::CFG_POTENTIAL_SIGN: potential_sign_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lpps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (dp_status),
    .cmd        (dp_cmd)
  );

  lpps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .status           (dp_status),
    .boundary_mode    (boundary_mode_r),
    .potential_sign   (potential_sign_r),
    .in_command       (in_command),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .in_load_x        (in_load_x),
    .in_load_y        (in_load_y),
    .in_load_charge   (in_load_charge),
    .out_first_x      (out_first_x),
    .out_first_y      (out_first_y),
    .out_second_x     (out_second_x),
    .out_second_y     (out_second_y),
    .out_first_moved  (out_first_moved),
    .out_second_moved (out_second_moved)
  );

`ifndef NO_ASSERTIONS
  // grid clearing pass follows every reset, so no transaction right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted during grid clearing pass");

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  // no memory activity other than capture while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (dp_cmd.op == lpps_pkg::OP_NONE || dp_cmd.op == lpps_pkg::OP_CAPTURE))
    else $error("datapath operation issued while idle");

  // result register never overwritten while a result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule
